// File: sv/dssq_pkg.sv
// ----------------------------------------------------------------------------
// dssq_pkg: shared types and the step table of the serial command sequencer
// Holds the command and result codes, the sequencer states and the function
// that describes each result of each command sequence.
// ----------------------------------------------------------------------------
package dssq_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned CH_W    = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned STEP_W  = 4;
  localparam int unsigned CFG_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INIT     = 3'd0,
    OP_FREQ     = 3'd1,
    OP_AMPL     = 3'd2,
    OP_PWR_UP   = 3'd3,
    OP_PWR_DOWN = 3'd4,
    OP_REJECT   = 3'd5
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_BYTE   = 3'd0,
    KIND_UPDATE = 3'd1,
    KIND_RESET  = 3'd2,
    KIND_POWER  = 3'd3,
    KIND_REJECT = 3'd4
  } kind_t;

  // Where the data byte of a step comes from.
  typedef enum logic [2:0] {
    SRC_CONST   = 3'd0,
    SRC_SEL_CH  = 3'd1,
    SRC_SEL_ALL = 3'd2,
    SRC_PLL     = 3'd3,
    SRC_VAL     = 3'd4
  } src_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RUN  = 1'b1
  } state_t;

  typedef enum logic {
    CFG_WIRE_MODE = 1'b0,
    CFG_PLL_MUL   = 1'b1
  } cfg_idx_t;

  // Device register addresses.
  localparam logic [BYTE_W-1:0] ADDR_CSR   = 8'h00;
  localparam logic [BYTE_W-1:0] ADDR_FR1   = 8'h01;
  localparam logic [BYTE_W-1:0] ADDR_FR2   = 8'h02;
  localparam logic [BYTE_W-1:0] ADDR_CPOW0 = 8'h05;
  localparam logic [BYTE_W-1:0] ADDR_CFTW0 = 8'h04;
  localparam logic [BYTE_W-1:0] ADDR_ACR   = 8'h06;

  localparam logic [BYTE_W-1:0] FR1_PWR_UP    = 8'hd0;
  localparam logic [BYTE_W-1:0] FR1_PWR_DOWN  = 8'hc0;
  localparam logic [BYTE_W-1:0] FR2_PHASE_CLR = 8'h10;
  localparam logic [BYTE_W-1:0] ACR_MULT_EN   = 8'h10;
  localparam logic [BYTE_W-1:0] CPOW_MASK     = 8'h3f;

  typedef struct packed {
    kind_t             kind;
    src_t              src;
    logic [BYTE_W-1:0] k;
    logic              fs;
    logic              fe;
    logic              pin;
    logic              last;
    logic              shift;
  } step_t;

  function automatic step_t mk(kind_t kind, src_t src, logic [BYTE_W-1:0] k,
                               logic fs, logic fe, logic pin, logic last);
    step_t s;
    s.kind  = kind;
    s.src   = src;
    s.k     = k;
    s.fs    = fs;
    s.fe    = fe;
    s.pin   = pin;
    s.last  = last;
    s.shift = (src == SRC_VAL);
    return s;
  endfunction

  function automatic step_t sbyte(src_t src, logic [BYTE_W-1:0] k, logic fs, logic fe,
                                  logic last);
    return mk(KIND_BYTE, src, k, fs, fe, 1'b0, last);
  endfunction

  function automatic step_t spin(kind_t kind, logic pin, logic last);
    return mk(kind, SRC_CONST, 8'h00, 1'b0, 1'b0, pin, last);
  endfunction

  // One entry per result: command sequence op, position step.
  function automatic step_t step_desc(op_t op, logic [STEP_W-1:0] step);
    step_t s;
    s = spin(KIND_REJECT, 1'b0, 1'b1);
    unique case (op)
      OP_INIT: begin
        unique case (step)
          4'd0:  s = spin(KIND_POWER, 1'b0, 1'b0);
          4'd1:  s = spin(KIND_RESET, 1'b0, 1'b0);
          4'd2:  s = sbyte(SRC_CONST, ADDR_CSR, 1'b1, 1'b0, 1'b0);
          4'd3:  s = sbyte(SRC_SEL_ALL, 8'h00, 1'b0, 1'b1, 1'b0);
          4'd4:  s = sbyte(SRC_CONST, ADDR_FR1, 1'b1, 1'b0, 1'b0);
          4'd5:  s = sbyte(SRC_PLL, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd6:  s = sbyte(SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd7:  s = sbyte(SRC_CONST, 8'h00, 1'b0, 1'b1, 1'b0);
          4'd8:  s = sbyte(SRC_CONST, ADDR_CPOW0, 1'b1, 1'b0, 1'b0);
          4'd9:  s = sbyte(SRC_CONST, 8'h00 & CPOW_MASK, 1'b0, 1'b0, 1'b0);
          4'd10: s = sbyte(SRC_CONST, 8'h00, 1'b0, 1'b1, 1'b0);
          4'd11: s = sbyte(SRC_CONST, ADDR_CSR, 1'b1, 1'b0, 1'b0);
          4'd12: s = sbyte(SRC_SEL_ALL, 8'h00, 1'b0, 1'b1, 1'b0);
          default: s = spin(KIND_UPDATE, 1'b0, 1'b1);
        endcase
      end
      OP_FREQ: begin
        unique case (step)
          4'd0:  s = sbyte(SRC_CONST, ADDR_CSR, 1'b1, 1'b0, 1'b0);
          4'd1:  s = sbyte(SRC_SEL_CH, 8'h00, 1'b0, 1'b1, 1'b0);
          4'd2:  s = sbyte(SRC_CONST, ADDR_CFTW0, 1'b1, 1'b0, 1'b0);
          4'd3:  s = sbyte(SRC_VAL, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd4:  s = sbyte(SRC_VAL, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd5:  s = sbyte(SRC_VAL, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd6:  s = sbyte(SRC_VAL, 8'h00, 1'b0, 1'b1, 1'b0);
          4'd7:  s = sbyte(SRC_CONST, ADDR_CSR, 1'b1, 1'b0, 1'b0);
          4'd8:  s = sbyte(SRC_SEL_ALL, 8'h00, 1'b0, 1'b1, 1'b0);
          4'd9:  s = sbyte(SRC_CONST, ADDR_FR2, 1'b1, 1'b0, 1'b0);
          4'd10: s = sbyte(SRC_CONST, FR2_PHASE_CLR, 1'b0, 1'b0, 1'b0);
          4'd11: s = sbyte(SRC_CONST, 8'h00, 1'b0, 1'b1, 1'b0);
          4'd12: s = sbyte(SRC_CONST, ADDR_FR2, 1'b1, 1'b0, 1'b0);
          4'd13: s = sbyte(SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd14: s = sbyte(SRC_CONST, 8'h00, 1'b0, 1'b1, 1'b0);
          default: s = spin(KIND_UPDATE, 1'b0, 1'b1);
        endcase
      end
      OP_AMPL: begin
        unique case (step)
          4'd0:  s = sbyte(SRC_CONST, ADDR_CSR, 1'b1, 1'b0, 1'b0);
          4'd1:  s = sbyte(SRC_SEL_CH, 8'h00, 1'b0, 1'b1, 1'b0);
          4'd2:  s = sbyte(SRC_CONST, ADDR_ACR, 1'b1, 1'b0, 1'b0);
          4'd3:  s = sbyte(SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd4:  s = sbyte(SRC_VAL, ACR_MULT_EN, 1'b0, 1'b0, 1'b0);
          4'd5:  s = sbyte(SRC_VAL, 8'h00, 1'b0, 1'b1, 1'b0);
          4'd6:  s = sbyte(SRC_CONST, ADDR_CSR, 1'b1, 1'b0, 1'b0);
          4'd7:  s = sbyte(SRC_SEL_ALL, 8'h00, 1'b0, 1'b1, 1'b0);
          default: s = spin(KIND_UPDATE, 1'b0, 1'b1);
        endcase
      end
      OP_PWR_UP: begin
        unique case (step)
          4'd0:  s = spin(KIND_POWER, 1'b0, 1'b0);
          4'd1:  s = sbyte(SRC_CONST, ADDR_FR1, 1'b1, 1'b0, 1'b0);
          4'd2:  s = sbyte(SRC_CONST, FR1_PWR_UP, 1'b0, 1'b0, 1'b0);
          4'd3:  s = sbyte(SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0);
          default: s = sbyte(SRC_CONST, 8'h00, 1'b0, 1'b1, 1'b1);
        endcase
      end
      OP_PWR_DOWN: begin
        unique case (step)
          4'd0:  s = sbyte(SRC_CONST, ADDR_FR1, 1'b1, 1'b0, 1'b0);
          4'd1:  s = sbyte(SRC_CONST, FR1_PWR_UP, 1'b0, 1'b0, 1'b0);
          4'd2:  s = sbyte(SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0);
          4'd3:  s = sbyte(SRC_CONST, FR1_PWR_DOWN, 1'b0, 1'b1, 1'b0);
          default: s = spin(KIND_POWER, 1'b1, 1'b1);
        endcase
      end
      default: s = spin(KIND_REJECT, 1'b0, 1'b1);
    endcase
    return s;
  endfunction

endpackage

// File: sv/dssq_if.sv
// ----------------------------------------------------------------------------
// dssq_if: command and result channels of the serial command sequencer
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dssq_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [2:0]  channel;
  logic [31:0] value;

  modport source (output valid, operation, channel, value, input ready);
  modport sink (input valid, operation, channel, value, output ready);
endinterface

interface dssq_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       frame_start;
  logic       frame_end;
  logic       power_pin;
  logic       last;

  modport source (output valid, kind, data_byte, frame_start, frame_end, power_pin, last,
                  input ready);
  modport sink (input valid, kind, data_byte, frame_start, frame_end, power_pin, last,
                output ready);
endinterface

// File: sv/dds_serial_command_sequencer_top.sv
// ----------------------------------------------------------------------------
// dds_serial_command_sequencer_top: serial command sequencer for a DDS chip
// Expands each command into serial bytes, reset, power pin and update results, or into a single reject result.
//
//   channel   | role   | payload
//   ----------+--------+----------------------------------------------------
//   cmd       | sink   | operation, channel, value
//   res       | source | kind, data_byte, frame_start, frame_end, power_pin,
//             |        | last
//   cfg_*     | write  | cfg_index selects wire_mode or pll_multiplier
//
// A command is taken while idle, then the step sequencer produces one result
// per cycle into the output register, up to 16 results per command, as long
// as the result side does not stall.
// The next command is taken as soon as the last result is loaded, even while it
// still waits in the output register. Reset clears the sequencer and the output
// valid and sets wire_mode to 2 and pll_multiplier to 20.
// ----------------------------------------------------------------------------
module dds_serial_command_sequencer_top #(
  parameter int unsigned CHANNELS = 2
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [dssq_pkg::CFG_W-1:0] cfg_data,
  dssq_cmd_if.sink               cmd,
  dssq_res_if.source             res
);
  import dssq_pkg::*;

  localparam int unsigned SEL_BASE = 8 - CHANNELS;
  localparam logic [BYTE_W-1:0] SEL_ALL = BYTE_W'(8'hff << SEL_BASE);

  state_t               state, state_next;
  logic [1:0]           wire_mode;
  logic [4:0]           pll_mul;
  op_t                  op;
  op_t                  op_dec;
  logic [CH_W-1:0]      chan;
  logic [VALUE_W-1:0]   shreg;
  logic [STEP_W-1:0]    step;
  step_t                desc;
  logic                 load;
  logic [BYTE_W-1:0]    byte_val;
  logic [BYTE_W-1:0]    sel_ch;
  logic [BYTE_W-1:0]    pll_byte;
  logic                 accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wire_mode <= 2'd2;
      pll_mul   <= 5'd20;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_WIRE_MODE: wire_mode <= cfg_data[1:0];
        CFG_PLL_MUL:   pll_mul   <= cfg_data;
        default:       wire_mode <= wire_mode;
      endcase
    end
  end

  // Command decode; a frequency or amplitude command to a channel outside the device, or an unknown code, is rejected.
  always_comb begin
    priority if (cmd.operation == OP_INIT) begin
      op_dec = OP_INIT;
    end else if (cmd.operation == OP_PWR_UP) begin
      op_dec = OP_PWR_UP;
    end else if (cmd.operation == OP_PWR_DOWN) begin
      op_dec = OP_PWR_DOWN;
    end else if ((cmd.operation == OP_FREQ) && (32'(cmd.channel) < CHANNELS)) begin
      op_dec = OP_FREQ;
    end else if ((cmd.operation == OP_AMPL) && (32'(cmd.channel) < CHANNELS)) begin
      op_dec = OP_AMPL;
    end else begin
      op_dec = OP_REJECT;
    end
  end

  assign accept = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.valid) state_next = S_RUN;
      S_RUN:  if (load && desc.last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // No command is taken while reset is held.
  always_comb begin
    cmd.ready = 1'b0;
    load      = 1'b0;
    unique case (state)
      S_IDLE: cmd.ready = !rst;
      S_RUN:  load = !res.valid || res.ready;
      default: cmd.ready = 1'b0;
    endcase
  end

  // Command registers; the value leaves the shift register one byte per use.
  // An amplitude is lined up so that its high byte comes out first.
  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= op_dec;
      chan  <= cmd.channel;
      shreg <= (op_dec == OP_AMPL) ? {cmd.value[15:0], 16'h0000} : cmd.value;
    end else if (load && desc.shift) begin
      shreg <= {shreg[VALUE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (accept) begin
      step <= '0;
    end else if (load) begin
      step <= step + 1'b1;
    end
  end

  assign desc     = step_desc(op, step);
  assign sel_ch   = BYTE_W'(8'h01 << (4'(SEL_BASE) + {1'b0, chan}));
  assign pll_byte = {(pll_mul >= 5'd8), pll_mul, 2'b00};

  always_comb begin
    unique case (desc.src)
      SRC_CONST:   byte_val = desc.k;
      SRC_SEL_CH:  byte_val = sel_ch | {6'b0, wire_mode};
      SRC_SEL_ALL: byte_val = SEL_ALL | {6'b0, wire_mode};
      SRC_PLL:     byte_val = pll_byte;
      SRC_VAL:     byte_val = shreg[VALUE_W-1 -: BYTE_W] | desc.k;
      default:     byte_val = desc.k;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res.kind        <= desc.kind;
      res.data_byte   <= byte_val;
      res.frame_start <= desc.fs;
      res.frame_end   <= desc.fe;
      res.power_pin   <= desc.pin;
      res.last        <= desc.last;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !cmd.ready)
    else $error("sequencer took a command while busy");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (load && desc.last) |=> cmd.ready)
    else $error("sequencer did not return to idle after the last result");

  a_reject_is_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.kind == KIND_REJECT)) |-> res.last)
    else $error("rejected result not marked last");

  a_frame_on_byte: assert property (@(posedge clk) disable iff (rst)
    (res.valid && (res.frame_start || res.frame_end)) |-> (res.kind == KIND_BYTE))
    else $error("frame mark on a result that is not a serial byte");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN) |-> ((op != OP_REJECT) || (step == '0)))
    else $error("rejected command ran past its single result");
`endif

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the DDS serial command sequencer
// Sends commands over the valid/ready command channel, expands each accepted
// command into its expected list of serial bytes and pin actions, and checks
// every result transfer against the oldest expected action, field by field.
// Both channels stall at random; registers are changed only while idle.
// ----------------------------------------------------------------------------
module tb;
  import dssq_pkg::*;

  localparam int CHANNELS    = 2;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 7;
  localparam int PHASE_ITEMS = 55;

  localparam logic [BYTE_W-1:0] ALL_SELECT = 8'(8'hff << (8 - CHANNELS));

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;
    logic              frame_end;
    logic              power_pin;
    logic              last;
  } dds_action_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_write;
  cfg_idx_t         cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dssq_cmd_if cmd_ch ();
  dssq_res_if res_ch ();

  dds_serial_command_sequencer_top #(.CHANNELS(CHANNELS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .res       (res_ch)
  );

  dds_action_t pending_actions[$];
  dds_action_t command_actions[$];
  logic [1:0]  cur_wire_mode;
  logic [4:0]  cur_pll_mul;
  int          stall_pct = 16;
  int          error_count = 0;
  int          cycle_count = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  task automatic add_action(kind_t kind, logic [7:0] data_byte, logic fs, logic fe,
                            logic pin);
    dds_action_t act;
    act.kind        = kind;
    act.data_byte   = data_byte;
    act.frame_start = fs;
    act.frame_end   = fe;
    act.power_pin   = pin;
    act.last        = 1'b0;
    command_actions.push_back(act);
  endtask

  // Register write frame: address byte, then n data bytes taken MSB first
  // from the low n bytes of data.
  task automatic add_frame(logic [7:0] addr, logic [31:0] data, int n);
    add_action(KIND_BYTE, addr, 1'b1, n == 0, 1'b0);
    for (int i = 0; i < n; i++) begin
      add_action(KIND_BYTE, data[8*(n-1-i) +: 8], 1'b0, i == n - 1, 1'b0);
    end
  endtask

  task automatic add_select(logic [7:0] sel);
    add_frame(ADDR_CSR, {24'h0, sel | {6'h0, cur_wire_mode}}, 1);
  endtask

  task automatic expand_command(logic [2:0] op, logic [2:0] ch, logic [31:0] val);
    dds_action_t act;
    logic [7:0]  ch_select;
    logic [7:0]  pll_byte;
    int          last_idx;
    ch_select = 8'(1 << (8 - CHANNELS + int'(ch)));
    pll_byte  = 8'(int'(cur_pll_mul) * 4 + (cur_pll_mul >= 5'd8 ? 8'h80 : 0));
    // Channel-addressed commands to a channel the chip lacks are refused.
    if ((op == OP_FREQ || op == OP_AMPL) && int'(ch) >= CHANNELS) op = OP_REJECT;
    case (op)
      OP_INIT: begin
        add_action(KIND_POWER, 8'h00, 1'b0, 1'b0, 1'b0);
        add_action(KIND_RESET, 8'h00, 1'b0, 1'b0, 1'b0);
        add_select(ALL_SELECT);
        add_frame(ADDR_FR1, {8'h0, pll_byte, 16'h0}, 3);
        add_frame(ADDR_CPOW0, {16'h0, 8'h00 & CPOW_MASK, 8'h00}, 2);
        add_select(ALL_SELECT);
        add_action(KIND_UPDATE, 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_FREQ: begin
        add_select(ch_select);
        add_frame(ADDR_CFTW0, val, 4);
        add_select(ALL_SELECT);
        add_frame(ADDR_FR2, {16'h0, FR2_PHASE_CLR, 8'h00}, 2);
        add_frame(ADDR_FR2, 32'h0, 2);
        add_action(KIND_UPDATE, 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_AMPL: begin
        add_select(ch_select);
        add_frame(ADDR_ACR, {8'h0, 8'h00, val[15:8] | ACR_MULT_EN, val[7:0]}, 3);
        add_select(ALL_SELECT);
        add_action(KIND_UPDATE, 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_PWR_UP: begin
        add_action(KIND_POWER, 8'h00, 1'b0, 1'b0, 1'b0);
        add_frame(ADDR_FR1, {8'h0, FR1_PWR_UP, 16'h0}, 3);
      end
      OP_PWR_DOWN: begin
        add_frame(ADDR_FR1, {8'h0, FR1_PWR_UP, 8'h00, FR1_PWR_DOWN}, 3);
        add_action(KIND_POWER, 8'h00, 1'b0, 1'b0, 1'b1);
      end
      default: begin
        add_action(KIND_REJECT, 8'h00, 1'b0, 1'b0, 1'b0);
      end
    endcase
    last_idx = command_actions.size() - 1;
    foreach (command_actions[i]) begin
      act      = command_actions[i];
      act.last = (i == last_idx);
      pending_actions.push_back(act);
    end
    command_actions.delete();
  endtask

  // ------------------------------------------------------------------ drivers

  // Called right after a rising edge. Valid stays high when no idle cycle
  // falls between two commands.
  task automatic send_command(logic [2:0] op, logic [2:0] ch, logic [31:0] val);
    while ($urandom_range(99) < stall_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.channel   <= ch;
    cmd_ch.value     <= val;
    do @(posedge clk); while (!cmd_ch.ready);
    expand_command(op, ch, val);
  endtask

  task automatic wait_results_drained();
    cmd_ch.valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_WIRE_MODE) cur_wire_mode = data[1:0];
    else cur_pll_mul = data;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    dds_action_t got;
    dds_action_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.kind        = kind_t'(res_ch.kind);
      got.data_byte   = res_ch.data_byte;
      got.frame_start = res_ch.frame_start;
      got.frame_end   = res_ch.frame_end;
      got.power_pin   = res_ch.power_pin;
      got.last        = res_ch.last;
      if (pending_actions.size() == 0) begin
        $display("%0t: unexpected result kind %0d byte %h fs %b fe %b pin %b last %b",
                 $time, got.kind, got.data_byte, got.frame_start, got.frame_end,
                 got.power_pin, got.last);
        error_count++;
      end else begin
        want = pending_actions.pop_front();
        if (got != want) begin
          $display("%0t: mismatch expected kind %0d byte %h fs %b fe %b pin %b last %b",
                   $time, want.kind, want.data_byte, want.frame_start, want.frame_end,
                   want.power_pin, want.last);
          $display("%0t:          actual   kind %0d byte %h fs %b fe %b pin %b last %b",
                   $time, got.kind, got.data_byte, got.frame_start, got.frame_end,
                   got.power_pin, got.last);
          error_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------- tests

  task automatic test_every_operation();
    for (int op = 0; op < 8; op++) begin
      send_command(3'(op), 3'($urandom_range(CHANNELS - 1)), $urandom);
    end
  endtask

  task automatic test_field_extremes();
    send_command(OP_FREQ, 3'd0, 32'h0000_0000);
    send_command(OP_FREQ, 3'(CHANNELS - 1), 32'hffff_ffff);
    send_command(OP_AMPL, 3'd0, 32'h0000_0000);
    send_command(OP_AMPL, 3'(CHANNELS - 1), 32'hffff_ffff);
    send_command(OP_AMPL, 3'd0, 32'h0000_ef00);
    // Commands without a target channel ignore the channel field.
    send_command(OP_INIT, 3'd7, 32'hffff_ffff);
    send_command(OP_PWR_UP, 3'd7, 32'hffff_ffff);
    send_command(OP_PWR_DOWN, 3'd5, 32'h0000_0000);
  endtask

  task automatic test_bad_channel();
    send_command(OP_FREQ, 3'(CHANNELS), 32'h1234_5678);
    send_command(OP_FREQ, 3'd7, 32'hffff_ffff);
    send_command(OP_AMPL, 3'(CHANNELS), 32'h0000_ffff);
    send_command(OP_AMPL, 3'd7, 32'h0000_0000);
  endtask

  task automatic test_register_settings();
    logic [CFG_W-1:0] wire_set [7] = '{5'd0, 5'd3, 5'b11100, 5'd1, 5'd2, 5'b10111, 5'd0};
    logic [CFG_W-1:0] pll_set  [7] = '{5'd0, 5'd31, 5'd4, 5'd20, 5'd7, 5'd8, 5'd16};
    for (int s = 0; s < 7; s++) begin
      wait_results_drained();
      write_register(CFG_WIRE_MODE, wire_set[s]);
      write_register(CFG_PLL_MUL, pll_set[s]);
      send_command(OP_INIT, 3'($urandom_range(7)), $urandom);
      send_command(OP_FREQ, 3'($urandom_range(CHANNELS - 1)), $urandom);
      send_command(OP_AMPL, 3'($urandom_range(CHANNELS - 1)), $urandom);
    end
  endtask

  task automatic test_random_traffic();
    logic [2:0]  op;
    logic [2:0]  ch;
    logic [31:0] val;
    for (int p = 0; p < PHASES; p++) begin
      wait_results_drained();
      write_register(CFG_WIRE_MODE, 5'($urandom_range(31)));
      write_register(CFG_PLL_MUL, ($urandom_range(3) == 0) ? 5'($urandom_range(31))
                                                           : 5'($urandom_range(4, 20)));
      // One phase runs with both channels streaming back to back.
      stall_pct = (p == 3) ? 0 : 16;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 85) begin
          op = 3'($urandom_range(OP_PWR_DOWN));
          ch = 3'($urandom_range(CHANNELS - 1));
        end else begin
          op = 3'($urandom_range(7));
          ch = 3'($urandom_range(7));
        end
        case ($urandom_range(9))
          0:       val = 32'h0000_0000;
          1:       val = 32'hffff_ffff;
          default: val = $urandom;
        endcase
        send_command(op, ch, val);
      end
    end
    stall_pct = 16;
  endtask

  // --------------------------------------------------------------------- main

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = CFG_WIRE_MODE;
    cfg_data         = '0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.operation = OP_INIT;
    cmd_ch.channel   = '0;
    cmd_ch.value     = '0;
    res_ch.ready     = 1'b0;
    cur_wire_mode    = 2'd2;
    cur_pll_mul      = 5'd20;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_every_operation();
    test_field_extremes();
    test_bad_channel();
    test_register_settings();
    test_random_traffic();

    wait_results_drained();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_actions.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: dds_serial_command_sequencer_top.f
sv/dssq_pkg.sv
sv/dssq_if.sv
sv/dds_serial_command_sequencer_top.sv
tb/sv/tb.sv
